>>> sv/frp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants of the receive-side opcode frame parser.
// ----------------------------------------------------------------------------
package frp_pkg;

   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned RSP_TDATA_W = 104;

   localparam logic [1:0] REG_NOP      = 2'd0;
   localparam logic [1:0] REG_TRANSFER = 2'd1;
   localparam logic [1:0] REG_MESSAGE  = 2'd2;

   localparam logic [7:0] NOP_RESET      = 8'd0;
   localparam logic [7:0] TRANSFER_RESET = 8'd1;
   localparam logic [7:0] MESSAGE_RESET  = 8'd2;

   localparam logic [2:0] PH_OPCODE = 3'd0;
   localparam logic [2:0] PH_T_HDR  = 3'd1;
   localparam logic [2:0] PH_T_PAY  = 3'd2;
   localparam logic [2:0] PH_M_HDR  = 3'd3;
   localparam logic [2:0] PH_M_PAY  = 3'd4;

   localparam logic [2:0] KIND_T_HDR  = 3'd0;
   localparam logic [2:0] KIND_T_PAY  = 3'd1;
   localparam logic [2:0] KIND_M_HDR  = 3'd2;
   localparam logic [2:0] KIND_M_PAY  = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN = 3'd4;

   localparam logic [3:0] TRANSFER_HDR_BYTES = 4'd9;
   localparam logic [3:0] MESSAGE_SIZE_BYTE  = 4'd1;
   localparam logic [3:0] MESSAGE_HDR_BYTES  = 4'd3;
   localparam logic [7:0] MSG_LIMIT          = 8'd32;

   typedef struct packed {
      logic [7:0] nop_code;
      logic [7:0] transfer_code;
      logic [7:0] message_code;
   } csr_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] entry_key;
      logic [15:0] sender_id;
      logic [7:0]  payload_size;
      logic [7:0]  data_byte;
      logic        too_long;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

>>> sv/frp_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frp_csr
// Opcode registers behind a simple peripheral bus port.
// ----------------------------------------------------------------------------
module frp_csr
   import frp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output csr_type                    codes
);

   csr_type    regs_ff;
   csr_type    regs_in;
   logic [1:0] index;
   logic       wr_fire;

   assign index      = csr_paddr[3:2];
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign codes      = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (wr_fire) begin
         case (index)
            REG_NOP:      regs_in.nop_code      = csr_pwdata[7:0];
            REG_TRANSFER: regs_in.transfer_code = csr_pwdata[7:0];
            REG_MESSAGE:  regs_in.message_code  = csr_pwdata[7:0];
            default:      regs_in = regs_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_NOP:      csr_prdata = {24'd0, regs_ff.nop_code};
         REG_TRANSFER: csr_prdata = {24'd0, regs_ff.transfer_code};
         REG_MESSAGE:  csr_prdata = {24'd0, regs_ff.message_code};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.nop_code      <= NOP_RESET;
         regs_ff.transfer_code <= TRANSFER_RESET;
         regs_ff.message_code  <= MESSAGE_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/frp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frp_core
// Frame state and single-pass decode of one received byte.
// ----------------------------------------------------------------------------
module frp_core
   import frp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_fire,
   input  wire logic [7:0] in_byte,
   input  wire csr_type    codes,
   output logic            res_valid,
   output rsp_type         res
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [63:0] key_ff, key_in;
   logic [15:0] client_ff, client_in;
   logic [7:0]  size_ff, size_in;
   logic [3:0]  cnt_inc;
   logic [7:0]  rem_dec;
   logic        over_limit;

   assign cnt_inc    = hdr_cnt_ff + 4'd1;
   assign rem_dec    = remaining_ff - 8'd1;
   assign over_limit = (size_ff > MSG_LIMIT);

   always_comb begin
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      client_in    = client_ff;
      size_in      = size_ff;
      res_valid    = 1'b0;
      res          = '0;
      case (phase_ff)
         PH_T_HDR: begin
            hdr_cnt_in = cnt_inc;
            if (cnt_inc < TRANSFER_HDR_BYTES) begin
               key_in = {in_byte, key_ff[63:8]};
            end else begin
               size_in          = in_byte;
               remaining_in     = in_byte;
               phase_in         = (in_byte == 8'd0) ? PH_OPCODE : PH_T_PAY;
               res_valid        = 1'b1;
               res.kind         = KIND_T_HDR;
               res.entry_key    = key_ff;
               res.payload_size = in_byte;
               res.last         = (in_byte == 8'd0);
            end
         end
         PH_T_PAY: begin
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) begin
               phase_in = PH_OPCODE;
            end
            res_valid        = 1'b1;
            res.kind         = KIND_T_PAY;
            res.payload_size = size_ff;
            res.data_byte    = in_byte;
            res.last         = (rem_dec == 8'd0);
         end
         PH_M_HDR: begin
            hdr_cnt_in = cnt_inc;
            if (cnt_inc == MESSAGE_SIZE_BYTE) begin
               size_in      = in_byte;
               remaining_in = in_byte;
            end else begin
               client_in = {in_byte, client_ff[15:8]};
               if (cnt_inc >= MESSAGE_HDR_BYTES) begin
                  phase_in         = (size_ff == 8'd0) ? PH_OPCODE : PH_M_PAY;
                  res_valid        = 1'b1;
                  res.kind         = KIND_M_HDR;
                  res.sender_id    = {in_byte, client_ff[15:8]};
                  res.payload_size = size_ff;
                  res.too_long     = over_limit;
                  res.last         = (size_ff == 8'd0);
               end
            end
         end
         PH_M_PAY: begin
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) begin
               phase_in = PH_OPCODE;
            end
            res_valid        = 1'b1;
            res.kind         = KIND_M_PAY;
            res.payload_size = size_ff;
            res.data_byte    = in_byte;
            res.too_long     = over_limit;
            res.last         = (rem_dec == 8'd0);
         end
         default: begin
            phase_in     = PH_OPCODE;
            hdr_cnt_in   = 4'd0;
            remaining_in = 8'd0;
            key_in       = 64'd0;
            client_in    = 16'd0;
            size_in      = 8'd0;
            if (in_byte == codes.nop_code) begin
               phase_in = PH_OPCODE;
            end else if (in_byte == codes.transfer_code) begin
               phase_in = PH_T_HDR;
            end else if (in_byte == codes.message_code) begin
               phase_in = PH_M_HDR;
            end else begin
               res_valid     = 1'b1;
               res.kind      = KIND_UNKNOWN;
               res.data_byte = in_byte;
               res.last      = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         hdr_cnt_ff   <= 4'd0;
         remaining_ff <= 8'd0;
         key_ff       <= 64'd0;
         client_ff    <= 16'd0;
         size_ff      <= 8'd0;
      end else if (in_fire) begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         client_ff    <= client_in;
         size_ff      <= size_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/frp_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frp_out
// Result register between the decode logic and the result channel.
// ----------------------------------------------------------------------------
module frp_out
   import frp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_fire,
   input  wire logic    res_valid,
   input  wire rsp_type res,
   input  wire logic    out_ready,
   output logic         out_valid,
   output logic         can_load,
   output rsp_type      out_res
);

   logic    valid_ff, valid_in;
   rsp_type res_ff;

   assign can_load  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = in_fire & res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire & res_valid) begin
         res_ff <= res;
      end
   end

endmodule
`default_nettype wire

>>> sv/rx_opcode_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rx_opcode_frame_parser
// Splits a received byte stream into transfer and message frames by opcode.
//
// Channels: req_* carries one received byte per transfer in req_tdata.
// rsp_* carries one result per transfer: rsp_tuser holds the kind (transfer
// header, transfer payload, message header, message payload, unknown
// opcode), rsp_tlast marks the final result of a frame and rsp_tdata holds
// key, client id, size, data byte and the oversized-message flag.
// Keep-alive bytes and header bytes before the last one give no result.
// The csr_* port holds the keep-alive, transfer and message opcodes.
// Throughput: one byte per cycle while no result waits on rsp_tready (see
// Stall). Output: a result appears on rsp_* in the cycle after the byte
// that completes it is accepted, set by the single result register.
// Reset: opcodes return to 0, 1 and 2, the parser waits for an opcode and
// the result register empties.
// Stall: while a result waits on a low rsp_tready, req_tready drops; it
// rises again in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module rx_opcode_frame_parser
   import frp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [63:0] entry_key, [79:64] sender_id, [87:80] payload_size,
   // [95:88] data_byte, [96] too_long, [103:97] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [2:0]                  rsp_tuser,   // [2:0] kind
   output logic                        rsp_tlast,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   csr_type codes;
   rsp_type res;
   rsp_type out_res;
   logic    res_valid;
   logic    can_load;
   logic    in_fire;

   assign req_tready = can_load;
   assign in_fire    = req_tvalid & can_load;

   frp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .codes       (codes)
   );

   frp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_byte   (req_tdata),
      .codes     (codes),
      .res_valid (res_valid),
      .res       (res)
   );

   frp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .res_valid (res_valid),
      .res       (res),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .can_load  (can_load),
      .out_res   (out_res)
   );

   assign rsp_tdata = {7'd0, out_res.too_long, out_res.data_byte, out_res.payload_size,
                       out_res.sender_id, out_res.entry_key};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

endmodule
`default_nettype wire
